/* rtl/spem_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spem_pkg
// Shared codes for the slotted-page entry manager: request kinds, status
// codes, configuration register indexes and controller states.
// ----------------------------------------------------------------------------
package spem_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_FIT   = 2'd2,
    OP_SPLIT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_ROOM = 2'd1,
    STAT_BAD     = 2'd2
  } status_t;

  typedef enum logic {
    CFG_NULL_TYPE = 1'b0,
    CFG_TRIE_MIN  = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS,
    S_CHECK,
    S_ADJUST,
    S_DONE
  } state_t;

endpackage

/* rtl/spem_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spem_cell
// One directory entry (type code and offset) in the rotating ring; loads
// the neighbor's entry on every shift.
// ----------------------------------------------------------------------------
module spem_cell #(
  parameter int OW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift,
  input  logic [7:0]    in_type,
  input  logic [OW-1:0] in_off,
  output logic [7:0]    type_q,
  output logic [OW-1:0] off_q
);

  logic [7:0]    type_r;
  logic [OW-1:0] off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r <= '0;
      off_r  <= '0;
    end else if (shift) begin
      type_r <= in_type;
      off_r  <= in_off;
    end
  end

  assign type_q = type_r;
  assign off_q  = off_r;

endmodule

/* rtl/slotted_page_entry_manager.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slotted_page_entry_manager
// Slotted-page directory: entries rotate through a ring of cells, edited at
// the head cell; alloc, free, fit query and split-entry search.
// ----------------------------------------------------------------------------
// Fit query and requests rejected up front: straight to the done state, then the result beat.
// Alloc and split-find: one full ring rotation, then the done state.
// Free: lookup rotation, check state, then adjust rotation (skipped if the check fails).
// One request at a time; the next is taken while a result beat waits.
// Synchronous reset clears all entries, counters (entry count back to one) and the result beat.
module slotted_page_entry_manager import spem_pkg::*; #(
  parameter int PAGE_BYTES    = 4096,
  parameter int ENTRY_BYTES   = 4,
  parameter int POINTER_BYTES = 8,
  parameter int MAX_ENTRIES   = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [12:0] in_byte_count,
  input  logic [7:0]  in_entry_kind,
  input  logic [7:0]  in_entry_index,
  input  logic [8:0]  in_link_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_result_index,
  output logic        out_fits,
  output logic [12:0] out_used_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int UW = $clog2(PAGE_BYTES + 1);
  localparam int OW = (UW > IW) ? UW : IW;
  localparam int XW = (CW > 8) ? CW : 8;
  localparam int SW = $clog2(PAGE_BYTES + 8192 + (MAX_ENTRIES + 1) * ENTRY_BYTES +
                             POINTER_BYTES + 512 * ENTRY_BYTES) + 1;

  state_t        state_r, state_nxt;
  op_t           op_r;
  logic [12:0]   bytes_r;
  logic [7:0]    code_r;
  logic [XW-1:0] idx_r;
  logic [IW-1:0] pos_r;
  logic [UW-1:0] used_r;
  logic [CW-1:0] count_r, fc_r;
  logic [IW-1:0] head_r;
  logic [7:0]    null_r, trie_r;
  logic [IW-1:0] slot_r;
  logic [OW-1:0] link_r, start_r, stop_r;
  logic [7:0]    ftype_r;
  logic [UW-1:0] mid_r;
  logic          found_r, last_r;
  logic [IW-1:0] first_r, second_r;
  logic [1:0]    res_status_r;
  logic [IW-1:0] res_index_r;
  logic          res_fits_r;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [7:0]    out_index_r;
  logic          out_fits_r;
  logic [12:0]   out_used_r;

  logic          acc, rotate, load_out, can_load, last_step, bad_chk;
  logic          in_range, live, at_idx, at_slot;
  logic [SW-1:0] base, dir_now, need;
  logic          room_reuse, room_app, alloc_ok, bad_idx;
  logic [XW-1:0] idx_in;
  logic [UW-1:0] mid_now;
  logic [OW-1:0] new_link;
  logic [7:0]    h_type, h_type_nxt;
  logic [OW-1:0] h_off, h_off_nxt;

  logic [7:0]    type_q [MAX_ENTRIES];
  logic [OW-1:0] off_q  [MAX_ENTRIES];

  genvar k;
  generate
    for (k = 0; k < MAX_ENTRIES; k++) begin : g_ring
      if (k == MAX_ENTRIES - 1) begin : g_tail
        spem_cell #(.OW(OW)) u_cell (
          .clk(clk), .rst_n(rst_n), .shift(rotate),
          .in_type(h_type_nxt), .in_off(h_off_nxt),
          .type_q(type_q[k]), .off_q(off_q[k])
        );
      end else begin : g_body
        spem_cell #(.OW(OW)) u_cell (
          .clk(clk), .rst_n(rst_n), .shift(rotate),
          .in_type(type_q[k+1]), .in_off(off_q[k+1]),
          .type_q(type_q[k]), .off_q(off_q[k])
        );
      end
    end
  endgenerate

  assign h_type    = type_q[0];
  assign h_off     = off_q[0];
  assign last_step = (pos_r == IW'(MAX_ENTRIES - 1));
  assign in_range  = (XW'(pos_r) < XW'(count_r));
  assign live      = (h_type != null_r);
  assign at_idx    = (XW'(pos_r) == idx_r);
  assign at_slot   = (pos_r == slot_r);
  assign can_load  = !out_valid_r || !out_stall;
  assign acc       = in_valid && !in_stall;

  assign base       = SW'(used_r) + SW'(in_byte_count);
  assign dir_now    = SW'(count_r) * SW'(ENTRY_BYTES);
  assign room_reuse = (base + dir_now) < SW'(PAGE_BYTES);
  assign room_app   = (count_r < CW'(MAX_ENTRIES)) &&
                      ((base + dir_now + SW'(ENTRY_BYTES)) < SW'(PAGE_BYTES));
  assign alloc_ok   = (fc_r != '0) ? room_reuse : room_app;
  assign need       = base + dir_now + SW'(POINTER_BYTES) +
                      SW'(in_link_count) * SW'(ENTRY_BYTES);
  assign idx_in     = XW'(in_entry_index);
  assign bad_idx    = (idx_in == '0) || (idx_in >= XW'(count_r));
  assign mid_now    = (dir_now >= SW'(PAGE_BYTES)) ? '0 :
                      UW'((SW'(PAGE_BYTES) - dir_now) >> 1);
  assign bad_chk    = (ftype_r == null_r) ||
                      ((SW'(start_r) + SW'(bytes_r)) > SW'(used_r));
  assign new_link   = at_slot ? h_off : link_r;

  always_comb begin
    h_type_nxt = h_type;
    h_off_nxt  = h_off;
    if (state_r == S_PASS && op_r == OP_ALLOC && at_slot) begin
      h_type_nxt = code_r;
      h_off_nxt  = OW'(used_r);
    end else if (state_r == S_ADJUST) begin
      if (at_idx) begin
        if (!last_r) begin
          h_type_nxt = null_r;
          h_off_nxt  = OW'(head_r);
        end
      end else if (in_range && live) begin
        if (h_off >= stop_r) begin
          h_off_nxt = h_off - OW'(bytes_r);
        end else if (h_off >= start_r) begin
          h_off_nxt = start_r;
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (op_t'(in_kind))
            OP_ALLOC: state_nxt = alloc_ok ? S_PASS : S_DONE;
            OP_FREE:  state_nxt = bad_idx ? S_DONE : S_PASS;
            OP_FIT:   state_nxt = S_DONE;
            OP_SPLIT: state_nxt = S_PASS;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_PASS: begin
        if (last_step) state_nxt = (op_r == OP_FREE) ? S_CHECK : S_DONE;
      end
      S_CHECK:  state_nxt = bad_chk ? S_DONE : S_ADJUST;
      S_ADJUST: begin
        if (last_step) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (can_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != S_IDLE);
    rotate   = (state_r == S_PASS) || (state_r == S_ADJUST);
    load_out = (state_r == S_DONE) && can_load;
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      null_r <= '0;
      trie_r <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NULL_TYPE: null_r <= cfg_data;
        CFG_TRIE_MIN:  trie_r <= cfg_data;
        default:       null_r <= null_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      used_r  <= '0;
      count_r <= CW'(1);
      fc_r    <= '0;
      head_r  <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (rotate) pos_r <= last_step ? '0 : pos_r + IW'(1);
      if (acc) begin
        op_r         <= op_t'(in_kind);
        bytes_r      <= in_byte_count;
        code_r       <= in_entry_kind;
        idx_r        <= idx_in;
        last_r       <= ((idx_in + XW'(1)) == XW'(count_r));
        mid_r        <= mid_now;
        slot_r       <= (fc_r != '0) ? head_r : IW'(count_r);
        found_r      <= 1'b0;
        first_r      <= '0;
        second_r     <= '0;
        res_status_r <= STAT_OK;
        res_index_r  <= '0;
        res_fits_r   <= 1'b0;
        unique case (op_t'(in_kind))
          OP_ALLOC: begin
            if (alloc_ok) res_index_r <= (fc_r != '0) ? head_r : IW'(count_r);
            else          res_status_r <= STAT_NO_ROOM;
          end
          OP_FREE:  if (bad_idx) res_status_r <= STAT_BAD;
          OP_FIT:   res_fits_r <= (need < SW'(PAGE_BYTES));
          OP_SPLIT: res_fits_r <= 1'b0;
          default:  res_fits_r <= 1'b0;
        endcase
      end
      if (state_r == S_PASS) begin
        if (op_r == OP_ALLOC && at_slot) link_r <= h_off;
        if (op_r == OP_FREE && at_idx) begin
          ftype_r <= h_type;
          start_r <= h_off;
        end
        if (op_r == OP_SPLIT && pos_r != '0 && in_range && live) begin
          if (!found_r && h_type >= trie_r && h_off >= OW'(mid_r)) begin
            found_r <= 1'b1;
            first_r <= pos_r;
          end
          if (second_r == '0 && h_off > OW'(mid_r)) second_r <= pos_r;
        end
        if (last_step && op_r == OP_ALLOC) begin
          used_r <= UW'(SW'(used_r) + SW'(bytes_r));
          if (fc_r != '0) begin
            fc_r   <= fc_r - CW'(1);
            head_r <= (new_link >= OW'(MAX_ENTRIES)) ? '0 : IW'(new_link);
          end else begin
            count_r <= count_r + CW'(1);
          end
        end
      end
      if (state_r == S_CHECK) begin
        if (bad_chk) res_status_r <= STAT_BAD;
        stop_r <= start_r + OW'(bytes_r);
      end
      if (state_r == S_ADJUST && last_step) begin
        used_r <= used_r - UW'(bytes_r);
        if (last_r) begin
          count_r <= count_r - CW'(1);
        end else begin
          head_r <= IW'(idx_r);
          fc_r   <= fc_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r  <= 1'b1;
      out_status_r <= res_status_r;
      out_index_r  <= 8'((op_r == OP_SPLIT) ? (found_r ? first_r : second_r) : res_index_r);
      out_fits_r   <= res_fits_r;
      out_used_r   <= 13'(used_r);
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_index = out_index_r;
  assign out_fits         = out_fits_r;
  assign out_used_bytes   = out_used_r;

  a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> pos_r == '0)
    else $error("ring not aligned while idle");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= CW'(MAX_ENTRIES)))
    else $error("entry count out of range");

  a_beat_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_status_r) &&
    $stable(out_index_r) && $stable(out_used_r))
    else $error("stalled result beat changed");

  a_beat_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result beat without completed request");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the slotted-page entry manager against a cycle-free directory model
// kept in the bench: allocate, free, fit query and split search under several
// register settings, with random idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import spem_pkg::*;

  localparam int PAGE_BYTES  = 4096;
  localparam int ENTRY_BYTES = 4;
  localparam int PTR_BYTES   = 8;
  localparam int MAX_ENTRIES = 256;
  localparam int SETTLE      = 2 * MAX_ENTRIES + 40;
  localparam int IDLE_LIMIT  = 20000;

  typedef struct packed {
    status_t     status;
    logic [7:0]  index;
    logic        fits;
    logic [12:0] used;
  } dir_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  op_t         in_kind = OP_FIT;
  logic [12:0] in_byte_count = '0;
  logic [7:0]  in_entry_kind = '0;
  logic [7:0]  in_entry_index = '0;
  logic [8:0]  in_link_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_result_index;
  logic        out_fits;
  logic [12:0] out_used_bytes;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = CFG_NULL_TYPE;
  logic [7:0]  cfg_data = '0;

  slotted_page_entry_manager u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_byte_count(in_byte_count), .in_entry_kind(in_entry_kind),
    .in_entry_index(in_entry_index), .in_link_count(in_link_count),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_result_index(out_result_index), .out_fits(out_fits),
    .out_used_bytes(out_used_bytes),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // directory shadow
  logic [7:0]  dir_type [MAX_ENTRIES];
  logic [12:0] dir_off [MAX_ENTRIES];
  int          dir_used, dir_count, dir_head, dir_free;
  logic [7:0]  null_code, trie_min;

  dir_result_t pending_q[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_left = 0;
  int          quiet = 0;

  function automatic bit entry_live(int i);
    return dir_type[i] != null_code;
  endfunction

  function automatic dir_result_t predict_dir(op_t k, int bytes, int code, int idx, int links);
    dir_result_t r;
    int base, slot, start, stop, need, mid, second;
    r = '{STAT_OK, 8'd0, 1'b0, 13'd0};
    case (k)
      OP_ALLOC: begin
        base = dir_used + bytes;
        slot = -1;
        if (dir_free > 0) begin
          if (base + dir_count * ENTRY_BYTES < PAGE_BYTES) begin
            slot = dir_head < MAX_ENTRIES ? dir_head : 0;
            dir_head = int'(dir_off[slot]);
            if (dir_head >= MAX_ENTRIES) dir_head = 0;
            dir_free--;
          end
        end else if (dir_count < MAX_ENTRIES &&
                     base + (dir_count + 1) * ENTRY_BYTES < PAGE_BYTES) begin
          slot = dir_count;
          dir_count++;
        end
        if (slot < 0) begin
          r.status = STAT_NO_ROOM;
        end else begin
          dir_type[slot] = 8'(code);
          dir_off[slot] = 13'(dir_used);
          dir_used = base;
          r.index = 8'(slot);
        end
      end
      OP_FREE: begin
        if (idx == 0 || idx >= dir_count || !entry_live(idx) ||
            int'(dir_off[idx]) + bytes > dir_used) begin
          r.status = STAT_BAD;
        end else begin
          start = int'(dir_off[idx]);
          stop = start + bytes;
          for (int i = 0; i < dir_count; i++) begin
            if (i != idx && entry_live(i)) begin
              if (int'(dir_off[i]) >= stop) dir_off[i] = 13'(int'(dir_off[i]) - bytes);
              else if (int'(dir_off[i]) >= start) dir_off[i] = 13'(start);
            end
          end
          dir_used -= bytes;
          if (idx == dir_count - 1) begin
            dir_count--;
          end else begin
            dir_off[idx] = 13'(dir_head);
            dir_type[idx] = null_code;
            dir_head = idx;
            dir_free++;
          end
        end
      end
      OP_FIT: begin
        need = dir_used + bytes + dir_count * ENTRY_BYTES + PTR_BYTES + links * ENTRY_BYTES;
        r.fits = need < PAGE_BYTES;
      end
      default: begin
        mid = dir_count * ENTRY_BYTES >= PAGE_BYTES ? 0 :
              (PAGE_BYTES - dir_count * ENTRY_BYTES) / 2;
        second = 0;
        for (int i = 1; i < dir_count; i++) begin
          if (entry_live(i)) begin
            if (dir_type[i] >= trie_min && int'(dir_off[i]) >= mid) begin
              if (r.index == 0) r.index = 8'(i);
            end
            if (second == 0 && int'(dir_off[i]) > mid) second = i;
          end
          if (r.index != 0) break;
        end
        if (r.index == 0) r.index = 8'(second);
      end
    endcase
    r.used = 13'(dir_used);
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk) begin
    dir_result_t w;
    if (out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        report("unexpected beat", 1, 0);
      end else begin
        w = pending_q.pop_front();
        if (out_status !== w.status) report("status", out_status, w.status);
        if (out_result_index !== w.index) report("result_index", out_result_index, w.index);
        if (out_fits !== w.fits) report("fits", out_fits, w.fits);
        if (out_used_bytes !== w.used) report("used_bytes", out_used_bytes, w.used);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= $urandom_range(99) < recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(op_t k, int bytes, int code, int idx, int links);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    in_kind        <= k;
    in_byte_count  <= 13'(bytes);
    in_entry_kind  <= 8'(code);
    in_entry_index <= 8'(idx);
    in_link_count  <= 9'(links);
    do @(posedge clk); while (in_stall);
    pending_q.push_back(predict_dir(k, bytes, code, idx, links));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t r, logic [7:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (r == CFG_NULL_TYPE) null_code = v;
    else trie_min = v;
  endtask

  task automatic set_regs(logic [7:0] nul, logic [7:0] trie);
    write_reg(CFG_NULL_TYPE, nul);
    write_reg(CFG_TRIE_MIN, trie);
  endtask

  task automatic random_item();
    int sel, idx, room;
    sel = $urandom_range(99);
    if (sel < 42) begin
      send_item(OP_ALLOC, ($urandom_range(19) == 0) ? $urandom_range(4096) : $urandom_range(40),
                $urandom_range(255), $urandom_range(255), $urandom_range(256));
    end else if (sel < 75) begin
      idx = $urandom_range(255);
      if ($urandom_range(9) != 0 && dir_count > 1) begin
        for (int t = 0; t < 8; t++) begin
          idx = $urandom_range(dir_count - 1, 1);
          if (entry_live(idx)) break;
        end
        room = dir_used - int'(dir_off[idx]);
        if (room < 0) room = 0;
        send_item(OP_FREE, $urandom_range(room > 60 ? 60 : room), $urandom_range(255), idx,
                  $urandom_range(256));
      end else begin
        send_item(OP_FREE, $urandom_range(4096), $urandom_range(255), idx, $urandom_range(256));
      end
    end else if (sel < 88) begin
      send_item(OP_FIT, $urandom_range(4096), $urandom_range(255), $urandom_range(255),
                $urandom_range(256));
    end else begin
      send_item(OP_SPLIT, $urandom_range(4096), $urandom_range(255), $urandom_range(255),
                $urandom_range(256));
    end
  endtask

  task automatic test_directed();
    send_item(OP_FIT, 0, 0, 0, 0);
    send_item(OP_FIT, 4096, 255, 255, 256);
    send_item(OP_SPLIT, 8191 & 4096, 0, 0, 0);
    send_item(OP_FREE, 0, 0, 0, 0);
    send_item(OP_FREE, 0, 0, 255, 0);
    send_item(OP_ALLOC, 4096, 5, 0, 0);
    send_item(OP_ALLOC, 0, 255, 0, 0);
    send_item(OP_ALLOC, 100, 0, 0, 0);
    send_item(OP_FREE, 10, 0, 2, 0);
    send_item(OP_ALLOC, 200, 3, 0, 0);
    send_item(OP_ALLOC, 1800, 9, 0, 0);
    send_item(OP_FREE, 4096, 0, 3, 0);
    send_item(OP_ALLOC, 50, 2, 0, 0);
    send_item(OP_SPLIT, 0, 0, 0, 0);
    send_item(OP_FREE, 150, 0, 3, 0);
    send_item(OP_ALLOC, 10, 7, 0, 0);
    send_item(OP_FREE, 50, 0, 5, 0);
    send_item(OP_FREE, 5, 0, 1, 0);
    send_item(OP_FIT, 1000, 0, 0, 100);
    send_item(OP_SPLIT, 0, 0, 0, 0);
    send_item(OP_ALLOC, 3000, 1, 0, 0);
  endtask

  task automatic test_fill();
    for (int i = 0; i < 260; i++) send_item(OP_ALLOC, $urandom_range(1), $urandom_range(255), 0, 0);
    send_item(OP_SPLIT, 0, 0, 0, 0);
    for (int i = 0; i < 60; i++) random_item();
  endtask

  task automatic test_random(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      if (($urandom_range(49) == 0)) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int j = 0; j < 15; j++) random_item();
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
      end
      random_item();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    hold_left = 1500;
    for (int i = 0; i < 12; i++) random_item();
    drain();
    for (int i = 0; i < 10; i++) random_item();
  endtask

  initial begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      dir_type[i] = '0;
      dir_off[i] = '0;
    end
    dir_used = 0;
    dir_count = 1;
    dir_head = 0;
    dir_free = 0;
    null_code = 8'd0;
    trie_min = 8'd1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fill();
    set_regs(8'd255, 8'd0);
    test_random(150, 0, 0);
    set_regs(8'd0, 8'd255);
    test_random(150, 80, 0);
    set_regs(8'd7, 8'd128);
    test_random(150, 0, 80);
    set_regs(8'd0, 8'd1);
    test_random(150, 35, 35);
    test_backpressure();
    drain();
    if (errors == 0 && pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
